// ----- rtl/core/jsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// jsrs_pkg
// Shared widths, register indexes, reset values and helpers for the
// joystick servo rate stepper.
// ----------------------------------------------------------------------------
package jsrs_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TICK_W     = 10;
  localparam int SCALE_W    = 6;
  localparam int POS_W      = 8;
  localparam int CHAN_W     = 3;
  localparam int BAND_W     = 4;
  localparam int DIVISOR_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int CHANNELS_DEF = 5;

  localparam logic [SAMPLE_W-1:0] DEAD_LOW_RST  = 10'd490;
  localparam logic [SAMPLE_W-1:0] DEAD_HIGH_RST = 10'd536;
  localparam logic [SCALE_W-1:0]  SCALE_RST     = 6'd20;
  localparam logic [POS_W-1:0]    POS_MIN_RST   = 8'd45;
  localparam logic [POS_W-1:0]    POS_MAX_RST   = 8'd105;
  localparam logic [TICK_W-1:0]   TICK_TOP_RST  = 10'd600;

  localparam logic [SAMPLE_W:0]   BAND_STEP = 11'd100;
  localparam logic [SAMPLE_W:0]   UP_BASE   = 11'd1128;
  localparam int                  BAND_MAX  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_LOW  = 3'd0,
    REG_DEAD_HIGH = 3'd1,
    REG_SCALE     = 3'd2,
    REG_POS_MIN   = 3'd3,
    REG_POS_MAX   = 3'd4,
    REG_TICK_TOP  = 3'd5
  } reg_idx_t;

  function automatic logic [POS_W-1:0] reset_pos(input logic [CHAN_W-1:0] ch);
    logic [POS_W-1:0] p;
    case (ch)
      3'd2, 3'd3: p = 8'd100;
      default:    p = 8'd75;
    endcase
    return p;
  endfunction

  // floor(v / 100) for v below 1200
  function automatic logic [BAND_W-1:0] band_of(input logic [SAMPLE_W:0] v);
    logic [BAND_W-1:0] b;
    b = '0;
    for (int k = 1; k <= BAND_MAX; k++) begin
      if (v >= SAMPLE_W'(0) + (SAMPLE_W+1)'(k * 100)) b = BAND_W'(k);
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/jsrs_ram.sv -----
// ----------------------------------------------------------------------------
// jsrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 5
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/jsrs_mod.sv -----
// ----------------------------------------------------------------------------
// jsrs_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module jsrs_mod
  import jsrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TICK_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [TICK_W-1:0]    shift;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   trial;

  assign trial = {remainder, shift[TICK_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(TICK_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shift <= {shift[TICK_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) remainder <= DIVISOR_W'(trial - {1'b0, dvs});
      else                      remainder <= trial[DIVISOR_W-1:0];
    end
  end

endmodule

// ----- rtl/core/joystick_servo_rate_stepper_core.sv -----
// ----------------------------------------------------------------------------
// joystick_servo_rate_stepper_core
// Per-channel servo position stepping from joystick samples.
// ----------------------------------------------------------------------------
// After input accept the result passes through position RAM read, remainder
// load, 10 remainder steps, completion and write-back to the output register.
// One beat is in work at a time; the next is accepted once the result sits
// in the output register, later while the output stalls.
// Reset (rst, synchronous) restores registers, counters and positions at once;
// per-entry valid bits stand in for the RAM contents, no clearing pass.
module joystick_servo_rate_stepper_core
  import jsrs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,    // [9:0] sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,    // [2:0] channel, [10:3] position
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_START = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SAMPLE_W-1:0] dead_low, dead_high;
  logic [SCALE_W-1:0]  rate_scale;
  logic [POS_W-1:0]    pos_min, pos_max;
  logic [TICK_W-1:0]   tick_top;

  logic [AW-1:0]       turn;
  logic [TICK_W-1:0]   tick_count;
  logic [CHANNELS-1:0] valid;
  logic [SAMPLE_W-1:0] sample;
  logic [POS_W-1:0]    pos;
  logic                zone_down, zone_up, div_zero;
  logic [DIVISOR_W-1:0] divisor;

  logic [POS_W-1:0]    ram_q, pos_new;
  logic [SAMPLE_W:0]   tick_inc, band_in;
  logic [BAND_W-1:0]   band;
  logic [DIVISOR_W-1:0] div_c;
  logic                mod_done;
  logic [DIVISOR_W-1:0] mod_rem;
  logic                out_free, do_write;
  logic [CHAN_W-1:0]   chan;

  assign chan      = CHAN_W'(turn);
  assign s_tready  = state == ST_IDLE && !rst;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign do_write  = state == ST_WRITE && out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_low   <= DEAD_LOW_RST;
      dead_high  <= DEAD_HIGH_RST;
      rate_scale <= SCALE_RST;
      pos_min    <= POS_MIN_RST;
      pos_max    <= POS_MAX_RST;
      tick_top   <= TICK_TOP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEAD_LOW:  dead_low   <= cfg_data;
        REG_DEAD_HIGH: dead_high  <= cfg_data;
        REG_SCALE:     rate_scale <= cfg_data[SCALE_W-1:0];
        REG_POS_MIN:   pos_min    <= cfg_data[POS_W-1:0];
        REG_POS_MAX:   pos_max    <= cfg_data[POS_W-1:0];
        REG_TICK_TOP:  tick_top   <= cfg_data;
        default: ;
      endcase
    end
  end

  jsrs_ram #(
    .WIDTH (POS_W),
    .DEPTH (CHANNELS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (turn),
    .wdata (pos_new),
    .re    (s_tvalid && s_tready),
    .raddr (turn),
    .rdata (ram_q)
  );

  jsrs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_START),
    .dividend  (tick_count),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign tick_inc = {1'b0, tick_count} + 1'b1;
  assign band_in  = (sample < dead_low) ? ({1'b0, sample} + BAND_STEP)
                                        : (UP_BASE - {1'b0, sample});
  assign band     = band_of(band_in);
  assign div_c    = DIVISOR_W'(band) * DIVISOR_W'(rate_scale);

  always_comb begin
    logic [POS_W:0] p;
    logic           hit;
    hit = !div_zero && mod_rem == '0;
    p   = {1'b0, pos};
    if (zone_down) begin
      if (hit) p = (pos == '0) ? {1'b0, pos_min} : p - 1'b1;
      if (p < {1'b0, pos_min}) p = {1'b0, pos_min};
    end else if (zone_up) begin
      if (hit) p = p + 1'b1;
      if (p > {1'b0, pos_max}) p = {1'b0, pos_max};
    end
    pos_new = p[POS_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_START;
      ST_START: state_next = ST_MOD;
      ST_MOD:   if (mod_done) state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      turn       <= '0;
      tick_count <= '0;
      valid      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_write)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == ST_IDLE && s_tvalid && turn == '0) begin
        tick_count <= (tick_inc > {1'b0, tick_top}) ? '0 : tick_inc[TICK_W-1:0];
      end
      if (do_write) begin
        valid[turn] <= 1'b1;
        turn        <= (turn == AW'(CHANNELS - 1)) ? '0 : turn + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) sample <= s_tdata[SAMPLE_W-1:0];
    if (state == ST_READ) begin
      pos       <= valid[turn] ? ram_q : reset_pos(chan);
      zone_down <= sample < dead_low;
      zone_up   <= sample > dead_high;
      divisor   <= div_c;
      div_zero  <= div_c == '0;
    end
    if (do_write) m_tdata <= {5'd0, pos_new, chan};
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for joystick_servo_rate_stepper_core. Samples go in as
// stream beats. A local model of the per-channel servo stepping predicts each
// result beat, and the checker compares it field by field. Directed cases
// cover zone edges, the clamps, the zero scale and the zero top. Random
// rounds follow, each with fresh register settings, under four idle/stall
// patterns on the two stream sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jsrs_pkg::*;

  localparam int CHAN_COUNT  = CHANNELS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int POS_RST_OUTER = 75;
  localparam int POS_RST_INNER = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX  = 10'd1023;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [POS_W-1:0]  position;
  } servo_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model state
  logic [SAMPLE_W-1:0] dead_low_q;
  logic [SAMPLE_W-1:0] dead_high_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [POS_W-1:0]    pos_min_q;
  logic [POS_W-1:0]    pos_max_q;
  logic [TICK_W-1:0]   tick_top_q;
  int                  turn_q;
  int                  tick_q;
  int                  servo_pos[8];

  servo_result_t pending_positions[$];
  int            mismatch_count;
  int            src_idle_pct;
  int            snk_stall_pct;
  int            quiet_cycles;

  joystick_servo_rate_stepper_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic reset_servo_model();
    dead_low_q  = DEAD_LOW_RST;
    dead_high_q = DEAD_HIGH_RST;
    scale_q     = SCALE_RST;
    pos_min_q   = POS_MIN_RST;
    pos_max_q   = POS_MAX_RST;
    tick_top_q  = TICK_TOP_RST;
    turn_q      = 0;
    tick_q      = 0;
    for (int i = 0; i < 8; i++) begin
      servo_pos[i] = (i == 2 || i == 3) ? POS_RST_INNER : POS_RST_OUTER;
    end
  endtask

  function automatic servo_result_t step_servo(input logic [SAMPLE_W-1:0] s);
    servo_result_t r;
    int ch;
    int pos;
    int divisor;
    int nxt;
    ch  = turn_q;
    pos = servo_pos[ch];
    if (ch == 0) begin
      nxt    = tick_q + 1;
      tick_q = (nxt > int'(tick_top_q)) ? 0 : (nxt & 'h3FF);
    end
    if (s < dead_low_q) begin
      divisor = ((int'(s) + 100) / 100) * int'(scale_q);
      if (divisor != 0 && (tick_q % divisor) == 0)
        pos = (pos == 0) ? int'(pos_min_q) : pos - 1;
      if (pos < int'(pos_min_q)) pos = int'(pos_min_q);
    end else if (s > dead_high_q) begin
      divisor = ((1128 - int'(s)) / 100) * int'(scale_q);
      if (divisor != 0 && (tick_q % divisor) == 0) pos = pos + 1;
      if (pos > int'(pos_max_q)) pos = int'(pos_max_q);
    end
    servo_pos[ch] = pos & 'hFF;
    turn_q = (ch + 1 >= CHAN_COUNT) ? 0 : ch + 1;
    r.channel  = CHAN_W'(ch);
    r.position = POS_W'(pos);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(16 - SAMPLE_W){1'b0}}, s};
    do @(posedge clk); while (!s_tready);
    pending_positions.push_back(step_servo(s));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEAD_LOW:  dead_low_q  = val;
      REG_DEAD_HIGH: dead_high_q = val;
      REG_SCALE:     scale_q     = val[SCALE_W-1:0];
      REG_POS_MIN:   pos_min_q   = val[POS_W-1:0];
      REG_POS_MAX:   pos_max_q   = val[POS_W-1:0];
      REG_TICK_TOP:  tick_top_q  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain all outstanding beats before touching the registers
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < CHAN_COUNT; i++) send_sample(10'd512);
  endtask

  // zero scale, crossed bounds, clamp with no step
  task automatic test_zero_scale_clamps();
    quiesce();
    write_reg(REG_SCALE, 10'd0);
    write_reg(REG_POS_MAX, 10'd0);
    write_reg(REG_POS_MIN, 10'd255);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd512);
  endtask

  // zero top, masked scale, overlapping zones, steps past 0 and 255
  task automatic test_wrap_and_overlap();
    quiesce();
    write_reg(REG_SCALE, 10'h3C1);
    write_reg(REG_TICK_TOP, 10'd0);
    write_reg(REG_POS_MIN, 10'h303);
    write_reg(REG_POS_MAX, 10'd255);
    write_reg(REG_DEAD_LOW, 10'd700);
    write_reg(REG_DEAD_HIGH, 10'd300);
    send_sample(10'd0);
    send_sample(10'd500);
    send_sample(SAMPLE_MAX);
    send_sample(10'd900);
    send_sample(10'd699);
  endtask

  task automatic test_zone_edges();
    quiesce();
    write_reg(REG_DEAD_LOW, DEAD_LOW_RST);
    write_reg(REG_DEAD_HIGH, DEAD_HIGH_RST);
    write_reg(REG_SPARE_6, 10'h2AA);
    write_reg(REG_SPARE_7, 10'h155);
    write_reg(REG_TICK_TOP, 10'd1023);
    send_sample(10'd489);
    send_sample(10'd490);
    send_sample(10'd536);
    send_sample(10'd537);
    send_sample(SAMPLE_MAX);
    send_sample(10'd0);
  endtask

  task automatic randomise_regs();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = 10'd0;
      1:       v = 10'd1023;
      default: v = CFG_DATA_W'($urandom_range(380, 560));
    endcase
    write_reg(REG_DEAD_LOW, v);
    case ($urandom_range(0, 5))
      0:       v = 10'd0;
      1:       v = 10'd1023;
      default: v = CFG_DATA_W'($urandom_range(470, 700));
    endcase
    write_reg(REG_DEAD_HIGH, v);
    v = CFG_DATA_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 7))
      0:       v[5:0] = 6'd0;
      1:       v[5:0] = 6'd63;
      2:       v[5:0] = SCALE_W'($urandom_range(4, 50));
      default: v[5:0] = SCALE_W'($urandom_range(1, 3));
    endcase
    write_reg(REG_SCALE, v);
    v = CFG_DATA_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 5))
      0:       v[7:0] = 8'd0;
      1:       v[7:0] = 8'd255;
      default: v[7:0] = POS_W'($urandom_range(0, 110));
    endcase
    write_reg(REG_POS_MIN, v);
    v = CFG_DATA_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 5))
      0:       v[7:0] = 8'd0;
      1:       v[7:0] = 8'd255;
      default: v[7:0] = POS_W'($urandom_range(80, 255));
    endcase
    write_reg(REG_POS_MAX, v);
    case ($urandom_range(0, 5))
      0:       v = 10'd0;
      1:       v = 10'd1023;
      default: v = CFG_DATA_W'($urandom_range(1, 40));
    endcase
    write_reg(REG_TICK_TOP, v);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE_6, CFG_DATA_W'($urandom_range(0, 1023)));
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE_7, CFG_DATA_W'($urandom_range(0, 1023)));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = 10'd0;
      1:       s = SAMPLE_MAX;
      2, 3:    s = (dead_low_q != 0) ? SAMPLE_W'($urandom_range(0, dead_low_q - 1)) : 10'd0;
      4, 5:    s = (dead_high_q != SAMPLE_MAX)
                   ? SAMPLE_W'($urandom_range(dead_high_q + 1, 1023)) : SAMPLE_MAX;
      default: s = SAMPLE_W'($urandom_range(0, 1023));
    endcase
    return s;
  endfunction

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
      for (int round = 0; round < 6; round++) begin
        quiesce();
        randomise_regs();
        for (int n = 0; n < 40; n++) send_sample(pick_sample());
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    servo_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("result beat with none pending", int'(m_tdata), 0);
      end else begin
        want = pending_positions.pop_front();
        if (m_tdata[2:0] != want.channel)
          report_mismatch("channel", int'(m_tdata[2:0]), int'(want.channel));
        if (m_tdata[10:3] != want.position)
          report_mismatch("position", int'(m_tdata[10:3]), int'(want.position));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_servo_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_zero_scale_clamps();
    test_wrap_and_overlap();
    test_zone_edges();
    test_random_traffic();
    quiesce();
    repeat (20) @(posedge clk);
    if (pending_positions.size() != 0)
      report_mismatch("result beats never arrived", pending_positions.size(), 0);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
